### src/rse_pkg.sv
package rse_pkg;

    localparam int ALPHABET_SIZE = 256;
    // Symbols are 8 bits wide, so entries beyond index 255 can never be reached.
    localparam int MEM_DEPTH     = (ALPHABET_SIZE < 256) ? ALPHABET_SIZE : 256;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int FREQ_W   = 9;
    localparam int CUMUL_W  = 16;
    localparam int TOTAL_W  = 17;
    localparam int STATE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = CUMUL_W + FREQ_W;

    localparam logic [STATE_W-1:0] LOWER_BOUND = 32'h0001_0000;
    localparam logic [BYTE_W-1:0]  BYTE_MASK   = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // Radix-16 divider: four quotient bits per cycle over a 32-bit dividend.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = STATE_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RENORM,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FLUSH,
        S_ERR
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic flush_start;
        logic check;
        logic emit_renorm;
        logic div_start;
        logic div_step;
        logic mul;
        logic add;
        logic flush_emit;
        logic emit_err;
    } t_ctrl;

    typedef struct packed {
        logic freq_zero;
        logic renorm_more;
        logic div_last;
        logic flush_last;
        logic out_free;
    } t_stat;

endpackage

### src/rse_ram.sv
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/rse_ctrl.sv
module rse_ctrl import rse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_acc,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_stat            i_stat,
    output logic             o_idle,
    output t_ctrl            o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    case (i_cmd)
                        CMD_ENCODE: n_state = S_CHECK;
                        CMD_FLUSH:  n_state = S_FLUSH;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK:  n_state = i_stat.freq_zero ? S_ERR : S_RENORM;
            S_RENORM: if (!i_stat.renorm_more) n_state = S_DIV;
            S_DIV:    if (i_stat.div_last) n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_IDLE;
            S_FLUSH:  if (i_stat.out_free && i_stat.flush_last) n_state = S_IDLE;
            S_ERR:    if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    case (i_cmd)
                        CMD_LOAD:   o_ctrl.load        = 1'b1;
                        CMD_ENCODE: o_ctrl.lookup      = 1'b1;
                        CMD_FLUSH:  o_ctrl.flush_start = 1'b1;
                        default:    o_ctrl = '0;
                    endcase
                end
            end
            S_CHECK:  o_ctrl.check = 1'b1;
            S_RENORM: begin
                if (!i_stat.renorm_more) begin
                    o_ctrl.div_start = 1'b1;
                end else if (i_stat.out_free) begin
                    o_ctrl.emit_renorm = 1'b1;
                end
            end
            S_DIV:    o_ctrl.div_step   = 1'b1;
            S_MUL:    o_ctrl.mul        = 1'b1;
            S_ADD:    o_ctrl.add        = 1'b1;
            S_FLUSH:  o_ctrl.flush_emit = i_stat.out_free;
            S_ERR:    o_ctrl.emit_err   = i_stat.out_free;
            default:  o_ctrl = '0;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

### src/rse_dp.sv
module rse_dp import rse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_final_byte,
    output logic              o_error
);

    logic [STATE_W-1:0]   r_coder;
    logic [TOTAL_W-1:0]   r_total;
    logic [MEM_DEPTH-1:0] r_valid;
    logic                 r_hit;
    logic [FREQ_W-1:0]    r_f;
    logic [CUMUL_W-1:0]   r_c;
    logic [STATE_W-1:0]   r_s;
    logic [1:0]           r_n;
    logic [STATE_W-1:0]   r_quo;
    logic [FREQ_W:0]      r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STATE_W-1:0]   r_prod;
    logic                 r_ovalid;
    logic [BYTE_W-1:0]    r_obyte;
    logic                 r_ofinal;
    logic                 r_oerr;

    logic                 in_range;
    logic [ADDR_W-1:0]    addr;
    logic                 load_we;
    logic [TOTAL_W-1:0]   base;
    logic [ENTRY_W-1:0]   wdata;
    logic [ENTRY_W-1:0]   rdata;
    logic [FREQ_W-1:0]    f_read;
    logic [STATE_W-1:0]   bound;
    logic                 out_free;
    logic                 emit;
    logic [STATE_W-1:0]   n_quo;
    logic [FREQ_W:0]      n_rem;
    logic [48:0]          prod_full;

    assign in_range = (32'(i_symbol) < ALPHABET_SIZE);
    assign addr     = i_symbol[ADDR_W-1:0];
    assign load_we  = i_ctrl.load && in_range;
    // index 0 restarts the cumulative sum
    assign base     = (i_symbol == '0) ? '0 : r_total;
    assign wdata    = {base[CUMUL_W-1:0], i_freq};

    rse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (i_ctrl.lookup),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // entries never loaded read as zero frequency
    assign f_read = r_hit ? rdata[FREQ_W-1:0] : '0;
    assign bound  = {7'd0, r_f, 16'd0};

    assign out_free = !r_ovalid || i_out_ready;
    assign emit     = i_ctrl.emit_renorm || i_ctrl.flush_emit || i_ctrl.emit_err;

    // four restoring quotient bits per step
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            n_rem = {n_rem[FREQ_W-1:0], n_quo[STATE_W-1]};
            n_quo = {n_quo[STATE_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_f}) begin
                n_rem    = n_rem - {1'b0, r_f};
                n_quo[0] = 1'b1;
            end
        end
    end

    assign prod_full = r_total * r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coder  <= LOWER_BOUND;
            r_total  <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_we) begin
                r_valid[addr] <= 1'b1;
                r_total       <= base + {{(TOTAL_W-FREQ_W){1'b0}}, i_freq};
                if (i_symbol == '0) begin
                    r_coder <= LOWER_BOUND;
                end
            end
            if (i_ctrl.add) begin
                r_coder <= r_prod + {16'd0, r_c} + {23'd0, r_rem[FREQ_W-1:0]};
            end
            if (i_ctrl.flush_emit && r_n == 2'd3) begin
                r_coder <= LOWER_BOUND;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.lookup) begin
            r_hit <= in_range && r_valid[addr];
        end
        if (i_ctrl.check) begin
            r_f <= f_read;
            r_c <= rdata[ENTRY_W-1:FREQ_W];
            r_s <= r_coder;
        end
        if (i_ctrl.flush_start) begin
            r_s <= r_coder;
            r_n <= 2'd0;
        end
        if (i_ctrl.emit_renorm || i_ctrl.flush_emit) begin
            r_s <= {8'd0, r_s[STATE_W-1:8]};
            r_n <= r_n + 2'd1;
        end
        if (i_ctrl.div_start) begin
            r_quo <= r_s;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_ctrl.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_ctrl.mul) begin
            r_prod <= prod_full[STATE_W-1:0];
        end
        if (emit) begin
            r_obyte  <= i_ctrl.emit_err ? '0 : (r_s[BYTE_W-1:0] & BYTE_MASK);
            r_ofinal <= i_ctrl.flush_emit && (r_n == 2'd3);
            r_oerr   <= i_ctrl.emit_err;
        end
    end

    assign o_stat.freq_zero   = (f_read == '0);
    assign o_stat.renorm_more = (r_s >= bound);
    assign o_stat.div_last    = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.flush_last  = (r_n == 2'd3);
    assign o_stat.out_free    = out_free;

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_final_byte = r_ofinal;
    assign o_error      = r_oerr;

endmodule

### src/rans_symbol_encoder_top.sv
// Byte-renormalised rANS encoder, lower bound 65536. Each word on the input
// channel is a load (write one frequency, in symbol order; symbol 0 restarts
// the cumulative sum and the coder state), an encode or a flush. An encode
// gives zero to two renormalisation bytes and then updates the 32-bit state;
// a symbol with no frequency loaded gives one error word and leaves the state
// alone. A flush gives the four state bytes, least significant first, marks
// the last with final_byte and restarts the state at 65536. Input words are
// taken one at a time. An encode reads the table, checks the frequency,
// emits any renormalisation bytes, then runs the radix-16 divider for
// state / freq and state % freq, followed by a multiply and an add. Output
// stalls hold back the renormalisation, flush and error bytes.
// The frequency and cumulative tables share one 256-entry memory; per-entry
// valid bits clear at reset, so no clearing pass is needed.
module rans_symbol_encoder_top import rse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_freq,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_final_byte,
    output logic              o_error
);

    t_ctrl ctrl;
    t_stat stat;
    logic  idle;
    logic  in_acc;

    // accept a word only while the sequencer is idle
    assign o_ready = idle;
    assign in_acc  = i_valid && idle;

    rse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_acc (in_acc),
        .i_cmd    (i_cmd),
        .i_stat   (stat),
        .o_idle   (idle),
        .o_ctrl   (ctrl)
    );

    // the output register inside lets the next word in while a result waits
    rse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_symbol     (i_symbol),
        .i_freq       (i_freq),
        .i_out_ready  (i_ready),
        .o_stat       (stat),
        .o_out_valid  (o_valid),
        .o_out_byte   (o_out_byte),
        .o_final_byte (o_final_byte),
        .o_error      (o_error)
    );

endmodule
